### rtl/core/ibs_pkg.sv
package ibs_pkg;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

endpackage

### rtl/core/ibs_ram.sv
module ibs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/ibs_search.sv
module ibs_search #(
    parameter int GRID_DEPTH  = 256,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [$clog2(GRID_DEPTH+1)-1:0]      i_cfg_size,
    input  logic                                 i_query,
    input  logic                                 i_restart,
    input  logic [VALUE_WIDTH-1:0]               i_x,
    output logic                                 o_idle,
    output logic [$clog2(GRID_DEPTH)-1:0]        o_raddr,
    input  logic [VALUE_WIDTH-1:0]               i_rdata,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [$clog2(GRID_DEPTH+1)-1:0]      o_bin
);
    import ibs_pkg::*;

    localparam int IW = $clog2(GRID_DEPTH);
    localparam int SW = $clog2(GRID_DEPTH + 1);
    localparam int RESET_LAST = (GRID_DEPTH < 256) ? GRID_DEPTH - 1 : 255;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LO   = 3'd1;
    localparam logic [2:0] S_HI   = 3'd2;
    localparam logic [2:0] S_G0   = 3'd3;
    localparam logic [2:0] S_WALK = 3'd4;
    localparam logic [2:0] S_HOLD = 3'd5;

    logic [2:0]             r_state, n_state;
    logic [IW-1:0]          r_hint, n_hint;
    logic [IW-1:0]          r_last, n_last;
    logic [VALUE_WIDTH-1:0] r_x, r_lo, r_hi;
    logic [SW-1:0]          r_bin, n_bin;
    logic                   r_out_valid, n_out_valid;
    logic [SW-1:0]          r_out_bin, n_out_bin;
    logic [IW-1:0]          start_hint;
    logic                   out_free;
    logic                   finish;
    logic [SW-1:0]          fin_bin;

    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        start_hint = i_restart ? IW'(1) : r_hint;
        if (start_hint > r_last) begin
            start_hint = r_last;
        end
        if (start_hint == '0) begin
            start_hint = IW'(1);
        end
    end

    always_comb begin
        if (i_cfg_size < SW'(2)) begin
            n_last = IW'(1);
        end else if (i_cfg_size > SW'(GRID_DEPTH)) begin
            n_last = IW'(GRID_DEPTH - 1);
        end else begin
            n_last = IW'(i_cfg_size - SW'(1));
        end
    end

    always_comb begin
        n_state     = r_state;
        n_hint      = r_hint;
        n_bin       = r_bin;
        o_raddr     = r_hint;
        finish      = 1'b0;
        fin_bin     = r_bin;
        unique case (r_state)
            S_IDLE: begin
                if (i_query) begin
                    n_hint  = start_hint;
                    o_raddr = start_hint - IW'(1);
                    n_state = S_LO;
                end
            end
            S_LO: begin
                o_raddr = r_last;
                n_state = S_HI;
            end
            S_HI: begin
                o_raddr = '0;
                n_state = S_G0;
            end
            S_G0: begin
                if (($signed(r_x) < $signed(r_lo)) || ($signed(r_x) > $signed(r_hi))) begin
                    finish  = 1'b1;
                    fin_bin = '0;
                end else if (r_x == i_rdata) begin
                    finish  = 1'b1;
                    fin_bin = SW'(2);
                end else begin
                    o_raddr = r_hint;
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if ((r_hint < r_last) && ($signed(i_rdata) < $signed(r_x))) begin
                    n_hint  = r_hint + IW'(1);
                    o_raddr = r_hint + IW'(1);
                end else begin
                    finish  = 1'b1;
                    fin_bin = SW'(r_hint) + SW'(1);
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (finish) begin
            n_bin   = fin_bin;
            n_state = out_free ? S_IDLE : S_HOLD;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid && !i_ready;
        n_out_bin   = r_out_bin;
        if (finish && out_free) begin
            n_out_valid = 1'b1;
            n_out_bin   = fin_bin;
        end else if ((r_state == S_HOLD) && out_free) begin
            n_out_valid = 1'b1;
            n_out_bin   = r_bin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hint      <= IW'(1);
            r_last      <= IW'(RESET_LAST);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_hint      <= n_hint;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_last <= n_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin     <= n_bin;
        r_out_bin <= n_out_bin;
        if ((r_state == S_IDLE) && i_query) begin
            r_x <= i_x;
        end
        if (r_state == S_LO) begin
            r_lo <= i_rdata;
        end
        if (r_state == S_HI) begin
            r_hi <= i_rdata;
        end
    end

    assign o_idle  = (r_state == S_IDLE);
    assign o_valid = r_out_valid;
    assign o_bin   = r_out_bin;

endmodule

### rtl/core/interp_bin_search_with_hint.sv
// Bin finder for linear interpolation over a stored ascending grid.
// The slave stream carries write and query words; tuser selects the kind.
// A write word stores sample_value at entry_index of the grid and gives no
// result. A query word returns one master word holding the one-based index
// of the right edge of the bin that holds the value, or zero when the value
// lies above the last entry or below the entry just under the hint.
// A query reads the entry just under the hint, the last entry and the first
// entry through the one grid read port, then walks the hint upward one entry
// per cycle. The configuration channel sets the number of grid points in
// use and is always ready; the user must write it only while no query is
// in flight, and the block itself does not enforce this.
// A result waits in the output register while the receiver stalls, and the
// next word is still accepted; a later query holds its result until the
// register frees. Reset sets the hint to one and the grid size to
// GRID_DEPTH, at most 256; the grid contents are undefined until written.
module interp_bin_search_with_hint #(
    parameter int GRID_DEPTH  = 256,
    parameter int VALUE_WIDTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_valid,
    output logic o_cfg_ready,
    input  logic [$clog2(GRID_DEPTH+1)-1:0] i_cfg_data,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    // entry_index, sample_value, restart
    input  logic [(($clog2(GRID_DEPTH)+VALUE_WIDTH+1+7)/8)*8-1:0] i_s_tdata,
    // op
    input  logic i_s_tuser,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    // bin
    output logic [(($clog2(GRID_DEPTH+1)+7)/8)*8-1:0] o_m_tdata
);
    import ibs_pkg::*;

    localparam int IW = $clog2(GRID_DEPTH);
    localparam int SW = $clog2(GRID_DEPTH + 1);
    localparam int OUT_TDW = ((SW + 7) / 8) * 8;

    logic                   s_accept;
    logic [IW-1:0]          entry_index;
    logic [VALUE_WIDTH-1:0] sample_value;
    logic                   restart;
    logic                   ram_we;
    logic [IW-1:0]          ram_raddr;
    logic [VALUE_WIDTH-1:0] ram_rdata;
    logic                   idle;
    logic [SW-1:0]          bin;

    assign entry_index  = i_s_tdata[IW-1:0];
    assign sample_value = i_s_tdata[IW+VALUE_WIDTH-1:IW];
    assign restart      = i_s_tdata[IW+VALUE_WIDTH];

    assign o_s_tready = idle;
    assign s_accept   = i_s_tvalid && idle;
    assign ram_we     = s_accept && (i_s_tuser == OP_WRITE)
                        && (SW'(entry_index) < SW'(GRID_DEPTH));
    assign o_cfg_ready = 1'b1;

    ibs_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (GRID_DEPTH)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (entry_index),
        .i_wdata (sample_value),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    ibs_search #(
        .GRID_DEPTH  (GRID_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_search (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_size (i_cfg_data),
        .i_query    (s_accept && (i_s_tuser == OP_QUERY)),
        .i_restart  (restart),
        .i_x        (sample_value),
        .o_idle     (idle),
        .o_raddr    (ram_raddr),
        .i_rdata    (ram_rdata),
        .o_valid    (o_m_tvalid),
        .i_ready    (i_m_tready),
        .o_bin      (bin)
    );

    assign o_m_tdata = OUT_TDW'(bin);

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    import ibs_pkg::*;

    localparam int STALL_LIMIT = 4000;

    typedef struct {
        logic               op;
        logic [7:0]         entry_index;
        logic signed [31:0] sample_value;
        logic               restart;
    } t_grid_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [8:0]  i_cfg_data = '0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    // entry_index, sample_value, restart
    logic [47:0] i_s_tdata = '0;
    // op
    logic        i_s_tuser = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    // bin
    logic [15:0] o_m_tdata;

    t_grid_word         pending_words[$];
    t_grid_word         cur_word;
    logic               word_taken = 1'b0;
    logic [8:0]         expected_bins[$];
    logic [8:0]         exp_bin;
    logic signed [31:0] grid_model[256];
    int                 hint_model = 1;
    logic [8:0]         size_model = 9'd256;
    int                 plan_grid[256];
    int                 grid_sizes[12] = '{256, 2, 0, 73, 511, 1, 40, 9, 300, 17, 3, 24};
    int                 send_idle_pct = 11;
    int                 recv_idle_pct = 61;
    int                 mismatches = 0;
    int                 quiet_cycles = 0;
    logic               progress;

    interp_bin_search_with_hint DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    always #6 i_clk = ~i_clk;

    function automatic logic [8:0] predict_bin(input logic signed [31:0] x, input logic rs);
        int last;
        last = (size_model < 9'd2) ? 1 : (size_model > 9'd256) ? 255 : int'(size_model) - 1;
        if (rs) hint_model = 1;
        if (hint_model > last) hint_model = last;
        if (hint_model < 1) hint_model = 1;
        if (x < grid_model[hint_model - 1] || x > grid_model[last]) return 9'd0;
        if (x == grid_model[0]) return 9'd2;
        while (hint_model < last && grid_model[hint_model] < x) hint_model++;
        return 9'(hint_model + 1);
    endfunction

    task automatic add_query(input int x, input logic rs);
        t_grid_word w;
        w.op = OP_QUERY;
        w.entry_index = 8'($urandom);
        w.sample_value = x;
        w.restart = rs;
        pending_words.push_back(w);
    endtask

    task automatic add_write(input int idx, input int val);
        t_grid_word w;
        plan_grid[idx] = val;
        w.op = OP_WRITE;
        w.entry_index = 8'(idx);
        w.sample_value = val;
        w.restart = 1'($urandom);
        pending_words.push_back(w);
    endtask

    // Loads entries 0..n-1 with an ascending set, written in shuffled order.
    task automatic load_grid(input int n, input int style);
        int vals[$];
        int order[$];
        for (int i = 0; i < n; i++) begin
            unique case (style)
                0: vals.push_back(int'($urandom));
                1: vals.push_back(int'($urandom) >>> 2);
                default: vals.push_back($urandom_range(0, 40) - 20);
            endcase
            order.push_back(i);
        end
        vals.sort();
        if (style == 0) begin
            vals[0] = int'(32'h8000_0000);
            vals[n - 1] = int'(32'h7fff_ffff);
        end
        order.shuffle();
        foreach (order[k]) add_write(order[k], vals[order[k]]);
    endtask

    function automatic int pick_x(input int pos);
        longint lo, hi, span;
        lo = plan_grid[(pos == 0) ? 0 : pos - 1];
        hi = plan_grid[pos];
        if (lo > hi) begin
            span = lo;
            lo = hi;
            hi = span;
        end
        span = hi - lo + 1;
        unique case ($urandom_range(0, 3))
            0: return int'(hi);
            1: return int'(lo);
            default: return int'(lo + longint'({$urandom, $urandom} % span));
        endcase
    endfunction

    task automatic wait_drained();
        do begin
            @(posedge i_clk);
            #1;
        end while (pending_words.size() != 0 || i_s_tvalid || expected_bins.size() != 0);
    endtask

    task automatic set_grid_size(input logic [8:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            i_m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            if (!i_s_tvalid || word_taken) begin
                word_taken = 1'b0;
                if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    cur_word = pending_words.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= {7'd0, cur_word.restart, cur_word.sample_value,
                                   cur_word.entry_index};
                    i_s_tuser  <= cur_word.op;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            progress = 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                size_model = i_cfg_data;
                progress = 1'b1;
            end
            if (i_s_tvalid && o_s_tready) begin
                word_taken = 1'b1;
                progress = 1'b1;
                if (cur_word.op == OP_WRITE) begin
                    grid_model[cur_word.entry_index] = cur_word.sample_value;
                end else begin
                    expected_bins.push_back(predict_bin(cur_word.sample_value,
                                                        cur_word.restart));
                end
            end
            if (o_m_tvalid && i_m_tready) begin
                progress = 1'b1;
                if (expected_bins.size() == 0) begin
                    $display("%0t: bin expected none, actual %0d", $time, o_m_tdata[8:0]);
                    mismatches++;
                end else begin
                    exp_bin = expected_bins.pop_front();
                    if (o_m_tdata[8:0] !== exp_bin) begin
                        $display("%0t: bin expected %0d, actual %0d", $time, exp_bin,
                                 o_m_tdata[8:0]);
                        mismatches++;
                    end
                end
            end
            quiet_cycles = progress ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial begin
        int   eff;
        int   pos;
        int   r;
        logic rs;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        eff = 256;
        load_grid(256, 0);
        add_query(plan_grid[0], 1'b0);
        add_query(plan_grid[255], 1'b0);
        add_query(plan_grid[10], 1'b0);
        add_query(plan_grid[10], 1'b1);
        add_query(pick_x(11), 1'b0);
        add_write(5, plan_grid[5]);
        add_query(plan_grid[5], 1'b1);
        add_query(plan_grid[0] + 1, 1'b1);
        load_grid(256, 1);
        add_query(int'(32'h8000_0000), 1'b1);
        add_query(int'(32'h7fff_ffff), 1'b0);
        add_query(plan_grid[255], 1'b0);
        add_query(plan_grid[0], 1'b1);
        // A single huge entry early in the grid stops the walk there.
        add_write(3, int'(32'h7fff_ffff));
        add_query(plan_grid[200], 1'b1);

        for (int s = 0; s < 12; s++) begin
            if (s > 0) begin
                wait_drained();
                repeat (16) @(posedge i_clk);
                send_idle_pct = (s < 4) ? 11 : (s < 8) ? 61 : 0;
                recv_idle_pct = (s < 4) ? 61 : (s < 8) ? 11 : 0;
                set_grid_size(9'(grid_sizes[s]));
                eff = (grid_sizes[s] < 2) ? 2 : (grid_sizes[s] > 256) ? 256 : grid_sizes[s];
                load_grid(eff, s % 3);
                // The hint may be left over from a larger grid.
                add_query(plan_grid[eff - 1], 1'b0);
            end
            pos = -1;
            for (int k = 0; k < 24; k++) begin
                r = $urandom_range(0, 99);
                if (r < 5) begin
                    add_write($urandom_range(0, 255), int'($urandom));
                end else if (r < 15) begin
                    add_query(int'($urandom), 1'($urandom));
                end else begin
                    if (pos < 0 || pos >= eff || $urandom_range(0, 19) == 0) begin
                        pos = $urandom_range(0, (eff - 1) / 4);
                        rs = ($urandom_range(0, 4) != 0);
                    end else begin
                        rs = 1'b0;
                    end
                    add_query(pick_x(pos), rs);
                    pos += ($urandom_range(0, 9) == 0) ? $urandom_range(1, eff)
                                                       : $urandom_range(0, 2);
                end
            end
        end

        wait_drained();
        repeat (300) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/ibs_pkg.sv
rtl/core/ibs_ram.sv
rtl/core/ibs_search.sv
rtl/core/interp_bin_search_with_hint.sv
tb/sv/tb.sv
